/* design/sis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sis_pkg
// Shared types and constants for the safety interlock supervisor.
// ============================================================================
package sis_pkg;

    // Width of the stored reset token. The port field stays 32 bits.
    localparam int TOKEN_WIDTH = 32;
    localparam int RESET_REQ_W = 32;
    localparam int ACK_W       = 32;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    localparam int ACT_W   = 8;
    localparam int LATCH_W = 9;

    // Mission and autonomy codes.
    localparam logic [3:0] MISSION_MANUAL = 4'd0;
    localparam logic [3:0] MISSION_REMOTE = 4'd7;
    localparam logic [3:0] MISSION_MAX    = 4'd8;

    localparam logic [2:0] AST_OFF       = 3'd0;
    localparam logic [2:0] AST_READY     = 3'd1;
    localparam logic [2:0] AST_DRIVING   = 3'd2;
    localparam logic [2:0] AST_EMERGENCY = 3'd4;

    localparam logic [1:0] STEER_NORMAL = 2'd0;
    localparam logic [1:0] STEER_BENCH  = 2'd1;

    // Health bit positions.
    localparam int HB_HW_OK      = 0;
    localparam int HB_STEER_OK   = 1;
    localparam int HB_TANK_OK    = 2;
    localparam int HB_PRESS_OK   = 3;
    localparam int HB_CMD_FRESH  = 4;
    localparam int HB_STATE_FRSH = 5;
    localparam int HB_COMP_OFF   = 6;

    // Fault bit masks.
    localparam logic [LATCH_W-1:0] F_HW       = 9'h001;
    localparam logic [LATCH_W-1:0] F_CMD      = 9'h010;
    localparam logic [LATCH_W-1:0] F_STATE    = 9'h020;
    localparam logic [LATCH_W-1:0] F_MODE     = 9'h080;
    localparam logic [LATCH_W-1:0] F_HOST     = 9'h100;
    localparam logic [LATCH_W-1:0] BENCH_MASK = F_HW | F_CMD | F_STATE | F_MODE;

    typedef struct packed {
        logic [3:0]             mission;
        logic [2:0]             autonomy_state;
        logic [1:0]             steer_mode;
        logic [6:0]             health_bits;
        logic [RESET_REQ_W-1:0] reset_request;
        logic                   targets_at_zero;
    } tick_in_t;

    typedef struct packed {
        logic             manual;
        logic             remote;
        logic             emerg;
        logic             bench;
        logic             valid;
        logic             arm_req;
        logic             ast_off;
        logic             ast_driving;
        logic             steer_normal;
        logic             bench_health_ok;
        logic [ACT_W-1:0] act;
    } decode_t;

    typedef struct packed {
        logic [ACT_W-1:0]   active_fault_bits;
        logic [LATCH_W-1:0] latched_fault_bits;
        logic               shutdown_closed;
        logic               manual_pedal_ok;
        logic               throttle_ok;
        logic               steering_ok;
        logic [3:0]         status_flags;
        logic [ACK_W-1:0]   acknowledged_reset;
    } tick_out_t;

endpackage
`default_nettype wire

/* design/sis_fault_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sis_fault_decode
// Decodes mode fields and health bits into active faults and mode flags.
// ============================================================================
module sis_fault_decode (
    input  wire sis_pkg::tick_in_t tick,
    output sis_pkg::decode_t       dec
);
    import sis_pkg::*;

    logic manual;
    logic remote;
    logic emerg;
    logic bench;
    logic valid;

    always_comb
    begin
        manual = (tick.mission == MISSION_MANUAL);
        remote = (tick.mission == MISSION_REMOTE);
        emerg  = (tick.autonomy_state == AST_EMERGENCY);
        bench  = remote && (tick.steer_mode == STEER_BENCH)
                 && (tick.autonomy_state == AST_OFF);
        valid  = (tick.mission <= MISSION_MAX)
                 && (tick.autonomy_state <= AST_EMERGENCY)
                 && (tick.steer_mode <= STEER_BENCH)
                 && !(manual && (tick.autonomy_state == AST_DRIVING));

        dec.manual       = manual;
        dec.remote       = remote;
        dec.emerg        = emerg;
        dec.bench        = bench;
        dec.valid        = valid;
        dec.ast_off      = (tick.autonomy_state == AST_OFF);
        dec.ast_driving  = (tick.autonomy_state == AST_DRIVING);
        dec.steer_normal = (tick.steer_mode == STEER_NORMAL);
        dec.bench_health_ok = tick.health_bits[HB_HW_OK]
                              && tick.health_bits[HB_CMD_FRESH]
                              && tick.health_bits[HB_STATE_FRSH];

        // Missions other than manual and remote arm in ready or driving; remote
        // arms only when off with normal steering.
        dec.arm_req = !manual && !bench && !emerg
                      && ((!remote && ((tick.autonomy_state == AST_READY)
                                       || (tick.autonomy_state == AST_DRIVING)))
                          || (remote && (tick.autonomy_state == AST_OFF)
                              && (tick.steer_mode == STEER_NORMAL)));

        dec.act[0] = !tick.health_bits[HB_HW_OK];
        dec.act[1] = !tick.health_bits[HB_STEER_OK];
        dec.act[2] = !tick.health_bits[HB_TANK_OK];
        dec.act[3] = !tick.health_bits[HB_PRESS_OK];
        dec.act[4] = !tick.health_bits[HB_CMD_FRESH];
        dec.act[5] = !tick.health_bits[HB_STATE_FRSH];
        dec.act[6] = tick.health_bits[HB_COMP_OFF];
        dec.act[7] = !valid;
    end

endmodule
`default_nettype wire

/* design/sis_interlock.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sis_interlock
// Holds the supervisor state and computes latch, reset and permissions.
// ============================================================================
module sis_interlock (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                advance,
    input  wire sis_pkg::decode_t              dec,
    input  wire [sis_pkg::RESET_REQ_W-1:0]     reset_request,
    input  wire                                targets_at_zero,
    output sis_pkg::tick_out_t                 result
);
    import sis_pkg::*;

    logic [LATCH_W-1:0]     latched_reg;
    logic [LATCH_W-1:0]     latched_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic                   holdoff_reg;
    logic                   holdoff_next;
    logic                   suppress_reg;
    logic                   suppress_next;
    logic [TOKEN_WIDTH-1:0] last_tok_reg;
    logic [TOKEN_WIDTH-1:0] last_tok_next;
    logic [TOKEN_WIDTH-1:0] ack_reg;
    logic [TOKEN_WIDTH-1:0] ack_next;
    logic                   bench_reg;
    logic                   steer_ok_reg;
    logic                   steer_ok_next;

    logic [TOKEN_WIDTH-1:0] tok;
    logic [LATCH_W-1:0]     act_ext;
    logic                   healthy;
    logic                   throttle;

    always_comb
    begin
        tok     = TOKEN_WIDTH'(reset_request);
        act_ext = LATCH_W'(dec.act);

        latched_next  = latched_reg;
        holdoff_next  = holdoff_reg;
        last_tok_next = last_tok_reg;
        ack_next      = ack_reg;

        if (armed_reg)
        begin
            latched_next = latched_next | act_ext;
        end
        if (bench_reg && steer_ok_reg)
        begin
            latched_next = latched_next | (act_ext & BENCH_MASK);
        end
        suppress_next = dec.emerg && suppress_reg;
        if (dec.emerg && !suppress_next)
        begin
            latched_next = latched_next | F_HOST;
        end

        if (holdoff_reg && dec.ast_off && (!dec.remote || dec.bench))
        begin
            holdoff_next = 1'b0;
        end

        // A newer token is always recorded; it clears only when safe.
        if ((tok != '0) && (tok > last_tok_reg))
        begin
            last_tok_next = tok;
            if ((dec.ast_off || dec.emerg) && (dec.act == '0) && targets_at_zero)
            begin
                latched_next  = '0;
                holdoff_next  = 1'b1;
                ack_next      = tok;
                suppress_next = dec.emerg;
            end
        end

        healthy       = (dec.act == '0) && (latched_next == '0);
        armed_next    = dec.arm_req && healthy && !holdoff_next;
        throttle      = armed_next && (dec.ast_driving || dec.remote);
        steer_ok_next = (throttle && dec.steer_normal)
                        || (dec.bench && dec.valid && dec.bench_health_ok
                            && (latched_next == '0) && !holdoff_next);

        result.active_fault_bits  = dec.act;
        result.latched_fault_bits = latched_next;
        result.shutdown_closed    = armed_next;
        result.manual_pedal_ok    = dec.manual && dec.ast_off && (latched_next == '0);
        result.throttle_ok        = throttle;
        result.steering_ok        = steer_ok_next;
        result.status_flags       = {armed_next, dec.bench, (latched_next != '0), healthy};
        result.acknowledged_reset = ACK_W'(ack_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg  <= '0;
            armed_reg    <= 1'b0;
            holdoff_reg  <= 1'b0;
            suppress_reg <= 1'b0;
            last_tok_reg <= '0;
            ack_reg      <= '0;
            bench_reg    <= 1'b0;
            steer_ok_reg <= 1'b0;
        end
        else if (advance)
        begin
            latched_reg  <= latched_next;
            armed_reg    <= armed_next;
            holdoff_reg  <= holdoff_next;
            suppress_reg <= suppress_next;
            last_tok_reg <= last_tok_next;
            ack_reg      <= ack_next;
            bench_reg    <= dec.bench;
            steer_ok_reg <= steer_ok_next;
        end
    end

    // An acknowledged reset always holds arming off on the next tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (ack_next != ack_reg) |=> holdoff_reg && !armed_reg)
        else $error("arming not held off after acknowledged reset");

    // The last seen token never falls behind the acknowledged one.
    assert property (@(posedge clk) disable iff (!rst_n)
        ack_reg <= last_tok_reg)
        else $error("acknowledged token ahead of last seen token");

endmodule
`default_nettype wire

/* design/safety_interlock_supervisor_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// safety_interlock_supervisor_core
// Per-tick safety supervisor: fault latching, reset handshake, permissions.
// ============================================================================
// Each input word is one control tick. The tick is captured in an input
// register, evaluated by one pass of shallow logic (mode decode, fault
// derivation, the fault latch update and a TOKEN_WIDTH-bit token compare)
// and written to a result register, and a new word is accepted every cycle
// while the result side keeps taking words. The result word becomes valid
// once its tick has moved from the input register into the result register.
// The supervisor state (fault latch, arming history, reset holdoff, token
// history) advances exactly once per tick, in the cycle the tick moves into
// the result register, so stalls on either side never change the outcome.
// After reset the latch is empty and no reset token has been seen.
module safety_interlock_supervisor_core (
    input  wire                            clk,
    input  wire                            rst_n,
    // s_tdata, from bit 0 up: mission[3:0], autonomy_state[2:0],
    // steer_mode[1:0], health_bits[6:0], reset_request[31:0],
    // targets_at_zero, zero fill.
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [sis_pkg::IN_DATA_W-1:0]   s_tdata,
    // m_tdata, from bit 0 up: active_fault_bits[7:0],
    // latched_fault_bits[8:0], shutdown_closed, manual_pedal_ok,
    // throttle_ok, steering_ok, status_flags[3:0], acknowledged_reset[31:0],
    // zero fill.
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [sis_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sis_pkg::*;

    tick_in_t  in_reg;
    tick_in_t  in_word;
    logic      in_vld_reg;
    tick_out_t res_reg;
    tick_out_t res_next;
    logic      out_vld_reg;
    logic      advance;
    decode_t   dec;

    // The input word is unpacked field by field, from bit 0 up.
    always_comb
    begin
        in_word.mission         = s_tdata[3:0];
        in_word.autonomy_state  = s_tdata[6:4];
        in_word.steer_mode      = s_tdata[8:7];
        in_word.health_bits     = s_tdata[15:9];
        in_word.reset_request   = s_tdata[47:16];
        in_word.targets_at_zero = s_tdata[48];
    end

    // The input register moves on whenever the result register is free or
    // is being drained in this cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= in_word;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    sis_fault_decode u_decode (
        .tick (in_reg),
        .dec  (dec)
    );

    sis_interlock u_interlock (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .dec             (dec),
        .reset_request   (in_reg.reset_request),
        .targets_at_zero (in_reg.targets_at_zero),
        .result          (res_next)
    );

    // Fields are packed from the lowest bit up in the order listed above.
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {
        {(OUT_DATA_W - $bits(tick_out_t)){1'b0}},
        res_reg.acknowledged_reset,
        res_reg.status_flags,
        res_reg.steering_ok,
        res_reg.throttle_ok,
        res_reg.manual_pedal_ok,
        res_reg.shutdown_closed,
        res_reg.latched_fault_bits,
        res_reg.active_fault_bits
    };

    // An armed result never carries an active or latched fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.shutdown_closed
        |-> (res_reg.latched_fault_bits == '0) && (res_reg.active_fault_bits == '0))
        else $error("armed with faults present");

    // Throttle permission implies the shutdown chain is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.throttle_ok |-> res_reg.shutdown_closed)
        else $error("throttle permitted while not armed");

    // A tick waiting for the result register stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_reg))
        else $error("pending tick lost or changed");

    // A result that is not taken is not replaced.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_tready |=> out_vld_reg && $stable(res_reg))
        else $error("stalled result overwritten");

endmodule
`default_nettype wire

/* test/safety_interlock_supervisor_core_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// safety_interlock_supervisor_core_tb
// Self-checking bench for the safety interlock supervisor core.
// ============================================================================
// A scripted opening covers the field extremes and the corner cases of the
// interlock: manual mode while driving, mission 8, stale and zero reset tokens,
// a new token while unsafe, and emergency suppression. A long random part
// follows. It is built mostly from plausible control episodes (recovery,
// driving, remote, bench, manual, emergency) with random content, plus some
// noise. Every accepted tick is run through a local model of the supervisor,
// and every result word is compared field by field against the oldest
// prediction. Both stream sides idle at random, and once the result side
// holds off for a long stretch so that the core backs up.
module safety_interlock_supervisor_core_tb;
    import sis_pkg::*;

    localparam int                N_TICKS        = 1875;
    localparam logic [6:0]        HEALTH_ALL_OK  = 7'h3F;
    localparam int                FAULT_MODE_BIT = 7;
    localparam longint unsigned   TOKEN_STEP     = 64'h1_0000_0000 / 2200;
    localparam int                HOLD_CYCLES    = 400;
    localparam int                HOLD_AFTER     = 700;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    safety_interlock_supervisor_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tick_in_t  tick_q[$];
    tick_out_t verdict_q[$];
    tick_in_t  cur_tick;
    tick_in_t  nxt_tick;
    logic      in_taken = 1'b0;

    // Model of the supervisor state.
    logic [LATCH_W-1:0]     lat_q;
    logic                   armed_q;
    logic                   holdoff_q;
    logic                   host_mute_q;
    logic [TOKEN_WIDTH-1:0] seen_tok_q;
    logic [TOKEN_WIDTH-1:0] acked_tok_q;
    logic                   bench_q;
    logic                   steer_q;

    // Largest token generated so far; any larger token is a new attempt.
    logic [31:0] gen_last;

    int errors       = 0;
    int ticks_in     = 0;
    int results_seen = 0;
    int ticks_sent   = 0;
    int armed_ticks  = 0;
    int resets_acked = 0;
    int bench_steers = 0;
    int host_latches = 0;
    int tx_gap       = 0;
    int tx_mode      = 0;
    int rx_gap       = 0;
    int rx_mode      = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // One control tick of the supervisor; advances the model state.
    function automatic tick_out_t supervise_tick(input tick_in_t t);
        tick_out_t              r;
        logic [ACT_W-1:0]       act;
        logic [TOKEN_WIDTH-1:0] tok;
        logic manual, remote, emerg, bench, valid, arm_req;
        logic healthy, armed, pedal, throttle, steer;
        manual = t.mission == MISSION_MANUAL;
        remote = t.mission == MISSION_REMOTE;
        emerg  = t.autonomy_state == AST_EMERGENCY;
        bench  = remote && t.steer_mode == STEER_BENCH && t.autonomy_state == AST_OFF;
        valid  = t.mission <= MISSION_MAX && t.autonomy_state <= AST_EMERGENCY
                 && t.steer_mode <= STEER_BENCH
                 && !(manual && t.autonomy_state == AST_DRIVING);

        // Active fault bit i is the inverse of health bit i, except that the compressor
        // bit flags a fault when set; the top bit is the mode check.
        act = '0;
        act[HB_HW_OK]      = !t.health_bits[HB_HW_OK];
        act[HB_STEER_OK]   = !t.health_bits[HB_STEER_OK];
        act[HB_TANK_OK]    = !t.health_bits[HB_TANK_OK];
        act[HB_PRESS_OK]   = !t.health_bits[HB_PRESS_OK];
        act[HB_CMD_FRESH]  = !t.health_bits[HB_CMD_FRESH];
        act[HB_STATE_FRSH] = !t.health_bits[HB_STATE_FRSH];
        act[HB_COMP_OFF]   = t.health_bits[HB_COMP_OFF];
        act[FAULT_MODE_BIT] = !valid;

        arm_req = !manual && !bench && !emerg
                  && ((!remote && (t.autonomy_state == AST_READY
                                   || t.autonomy_state == AST_DRIVING))
                      || (remote && t.autonomy_state == AST_OFF
                          && t.steer_mode == STEER_NORMAL));

        if (armed_q)
            lat_q = lat_q | LATCH_W'(act);
        if (bench_q && steer_q)
            lat_q = lat_q | (LATCH_W'(act) & BENCH_MASK);
        if (!emerg)
            host_mute_q = 1'b0;
        if (emerg && !host_mute_q)
        begin
            lat_q = lat_q | F_HOST;
            host_latches++;
        end

        if (holdoff_q && t.autonomy_state == AST_OFF && (!remote || bench))
            holdoff_q = 1'b0;
        tok = TOKEN_WIDTH'(t.reset_request);
        if (tok != '0 && tok > seen_tok_q)
        begin
            seen_tok_q = tok;
            if ((t.autonomy_state == AST_OFF || emerg) && act == '0 && t.targets_at_zero)
            begin
                lat_q       = '0;
                holdoff_q   = 1'b1;
                acked_tok_q = tok;
                host_mute_q = emerg;
                resets_acked++;
            end
        end

        healthy  = act == '0 && lat_q == '0;
        armed    = arm_req && healthy && !holdoff_q;
        pedal    = manual && t.autonomy_state == AST_OFF && lat_q == '0;
        throttle = armed && (t.autonomy_state == AST_DRIVING || remote);
        steer    = (throttle && t.steer_mode == STEER_NORMAL)
                   || (bench && valid && t.health_bits[HB_HW_OK]
                       && t.health_bits[HB_CMD_FRESH] && t.health_bits[HB_STATE_FRSH]
                       && lat_q == '0 && !holdoff_q);

        armed_q = armed;
        bench_q = bench;
        steer_q = steer;
        if (armed)
            armed_ticks++;
        if (bench && steer)
            bench_steers++;

        r.active_fault_bits  = act;
        r.latched_fault_bits = lat_q;
        r.shutdown_closed    = armed;
        r.manual_pedal_ok    = pedal;
        r.throttle_ok        = throttle;
        r.steering_ok        = steer;
        r.status_flags       = {armed, bench, lat_q != '0, healthy};
        r.acknowledged_reset = ACK_W'(acked_tok_q);
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_tick(input tick_in_t t);
        logic [IN_DATA_W-1:0] d;
        d        = '0;
        d[3:0]   = t.mission;
        d[6:4]   = t.autonomy_state;
        d[8:7]   = t.steer_mode;
        d[15:9]  = t.health_bits;
        d[47:16] = t.reset_request;
        d[48]    = t.targets_at_zero;
        return d;
    endfunction

    function automatic tick_out_t unpack_result(input logic [OUT_DATA_W-1:0] d);
        tick_out_t r;
        r.active_fault_bits  = d[7:0];
        r.latched_fault_bits = d[16:8];
        r.shutdown_closed    = d[17];
        r.manual_pedal_ok    = d[18];
        r.throttle_ok        = d[19];
        r.steering_ok        = d[20];
        r.status_flags       = d[24:21];
        r.acknowledged_reset = d[56:25];
        return r;
    endfunction

    // Gap lengths: mode 0 never idles, mode 1 idles lightly, mode 2 heavily.
    function automatic int draw_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 75) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    endfunction

    // A fresh token climbs with the tick count so that the upper token bits
    // get exercised; otherwise zero, a repeat, or an older value.
    function automatic logic [31:0] next_token(input bit fresh);
        longint unsigned floor_v;
        longint unsigned cand;
        int r;
        if (fresh)
        begin
            floor_v = longint'(tick_q.size()) * TOKEN_STEP;
            cand    = longint'(gen_last) + 1;
            if (floor_v > cand)
                cand = floor_v;
            cand = cand + $urandom_range(0, int'(TOKEN_STEP / 2));
            if (cand > 64'hFFFF_FFFF)
                cand = 64'hFFFF_FFFF;
            gen_last = cand[31:0];
            return gen_last;
        end
        r = $urandom_range(0, 3);
        if (r < 2)
            return '0;
        if (r == 2)
            return gen_last;
        return $urandom_range(0, gen_last);
    endfunction

    function automatic logic [6:0] faulty_health();
        if ($urandom_range(0, 3) == 0)
            return 7'($urandom);
        return HEALTH_ALL_OK ^ (7'h01 << $urandom_range(0, 6));
    endfunction

    function automatic logic [3:0] drive_mission();
        logic [3:0] m;
        m = 4'($urandom_range(1, 7));
        return (m == MISSION_REMOTE) ? MISSION_MAX : m;
    endfunction

    task automatic add_tick(input logic [3:0] m, input logic [2:0] a, input logic [1:0] s,
                            input logic [6:0] hb, input logic [31:0] tok, input logic tz);
        tick_in_t t;
        t.mission         = m;
        t.autonomy_state  = a;
        t.steer_mode      = s;
        t.health_bits     = hb;
        t.reset_request   = tok;
        t.targets_at_zero = tz;
        tick_q.push_back(t);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Sender: offers the next word once the current one is taken or after a gap.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (tick_q.size() > 0)
            begin
                if (ticks_sent % 150 == 0)
                    tx_mode = $urandom_range(0, 2);
                nxt_tick = tick_q.pop_front();
                cur_tick <= nxt_tick;
                s_tdata  <= pack_tick(nxt_tick);
                s_tvalid <= 1'b1;
                ticks_sent++;
                tx_gap = draw_gap(tx_mode);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (results_seen % 150 == 0)
                    rx_mode = $urandom_range(0, 2);
                m_tready <= 1'b1;
                rx_gap = draw_gap(rx_mode);
            end
        end
    end

    // Predict on every accepted tick and check every accepted result word.
    always @(posedge clk)
    begin
        tick_out_t want;
        tick_out_t got;
        in_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            verdict_q.push_back(supervise_tick(cur_tick));
            ticks_in++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got = unpack_result(m_tdata);
            if (verdict_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: result word with no tick outstanding, actual 0x%0h",
                         $time, m_tdata);
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("active_fault_bits", want.active_fault_bits, got.active_fault_bits);
                check_field("latched_fault_bits", want.latched_fault_bits,
                            got.latched_fault_bits);
                check_field("shutdown_closed", want.shutdown_closed, got.shutdown_closed);
                check_field("manual_pedal_ok", want.manual_pedal_ok, got.manual_pedal_ok);
                check_field("throttle_ok", want.throttle_ok, got.throttle_ok);
                check_field("steering_ok", want.steering_ok, got.steering_ok);
                check_field("status_flags", want.status_flags, got.status_flags);
                check_field("acknowledged_reset", want.acknowledged_reset,
                            got.acknowledged_reset);
            end
        end
    end

    initial
    begin
        int kind;
        int n;
        logic [2:0] a;
        logic [3:0] m;

        lat_q       = '0;
        armed_q     = 1'b0;
        holdoff_q   = 1'b0;
        host_mute_q = 1'b0;
        seen_tok_q  = '0;
        acked_tok_q = '0;
        bench_q     = 1'b0;
        steer_q     = 1'b0;

        // Scripted opening.
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, 7'h00, 32'd0, 1'b0);
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, 7'h7F, 32'd0, 1'b1);
        // Manual mission while driving is an invalid mode.
        add_tick(MISSION_MANUAL, AST_DRIVING, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        // Mission 8 is valid but neither manual nor remote, so it can arm.
        add_tick(MISSION_MAX, AST_READY, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(MISSION_MAX, AST_DRIVING, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        // A stale command while armed latches.
        add_tick(MISSION_MAX, AST_DRIVING, STEER_NORMAL, 7'h2F, 32'd0, 1'b0);
        // New token while unsafe: recorded, nothing cleared.
        add_tick(MISSION_MAX, AST_DRIVING, STEER_NORMAL, HEALTH_ALL_OK, 32'd5, 1'b1);
        // Same token again, then a zero token: both ignored.
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd5, 1'b1);
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b1);
        // Targets not at zero blocks the reset.
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd6, 1'b0);
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd7, 1'b1);
        // Holdoff keeps arming off until the state returns to off.
        add_tick(4'd3, AST_READY, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(4'd3, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(4'd3, AST_READY, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(MISSION_REMOTE, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        // Bench steering, then a stale command while bench steering was allowed.
        add_tick(MISSION_REMOTE, AST_OFF, STEER_BENCH, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(MISSION_REMOTE, AST_OFF, STEER_BENCH, 7'h2F, 32'd0, 1'b0);
        // Emergency latches the host bit; a reset during emergency suppresses it.
        add_tick(MISSION_REMOTE, AST_EMERGENCY, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(MISSION_REMOTE, AST_EMERGENCY, STEER_NORMAL, HEALTH_ALL_OK, 32'd100, 1'b1);
        add_tick(MISSION_REMOTE, AST_EMERGENCY, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(4'd15, 3'd7, 2'd3, HEALTH_ALL_OK, 32'd101, 1'b1);
        add_tick(4'd9, 3'd5, 2'd2, 7'h7F, 32'd0, 1'b0);
        add_tick(MISSION_MANUAL, AST_OFF, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        add_tick(MISSION_REMOTE, AST_EMERGENCY, STEER_NORMAL, HEALTH_ALL_OK, 32'd0, 1'b0);
        gen_last = 32'd101;

        // Random episodes.
        while (tick_q.size() < N_TICKS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 22)
            begin
                // Recovery: safe tick with a new token, then release the holdoff.
                a = ($urandom_range(0, 4) == 0) ? AST_EMERGENCY : AST_OFF;
                add_tick(4'($urandom_range(0, 8)), a, 2'($urandom_range(0, 1)),
                         HEALTH_ALL_OK, next_token(1'b1), 1'b1);
                if (a == AST_EMERGENCY)
                    repeat ($urandom_range(1, 3))
                        add_tick(4'($urandom_range(0, 8)), AST_EMERGENCY, STEER_NORMAL,
                                 HEALTH_ALL_OK, next_token(1'b0), 1'($urandom));
                add_tick(4'($urandom_range(0, 6)), AST_OFF, STEER_NORMAL, HEALTH_ALL_OK,
                         next_token(1'b0), 1'($urandom));
            end
            else if (kind < 42)
            begin
                n = $urandom_range(3, 12);
                repeat (n)
                begin
                    a = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 3))
                                                    : 3'($urandom_range(1, 2));
                    add_tick(drive_mission(), a, 2'($urandom_range(0, 1)),
                             ($urandom_range(0, 99) < 8) ? faulty_health() : HEALTH_ALL_OK,
                             next_token($urandom_range(0, 19) == 0), 1'($urandom));
                end
            end
            else if (kind < 57)
            begin
                n = $urandom_range(3, 10);
                repeat (n)
                    add_tick(MISSION_REMOTE,
                             ($urandom_range(0, 9) == 0) ? AST_DRIVING : AST_OFF,
                             STEER_NORMAL,
                             ($urandom_range(0, 99) < 8) ? faulty_health() : HEALTH_ALL_OK,
                             next_token($urandom_range(0, 19) == 0), 1'($urandom));
            end
            else if (kind < 70)
            begin
                n = $urandom_range(3, 10);
                repeat (n)
                    add_tick(MISSION_REMOTE, AST_OFF, STEER_BENCH,
                             ($urandom_range(0, 99) < 15) ? faulty_health() : HEALTH_ALL_OK,
                             next_token($urandom_range(0, 19) == 0), 1'($urandom));
            end
            else if (kind < 80)
            begin
                n = $urandom_range(2, 6);
                repeat (n)
                    add_tick(MISSION_MANUAL,
                             ($urandom_range(0, 9) == 0) ? AST_DRIVING : AST_OFF,
                             STEER_NORMAL,
                             ($urandom_range(0, 99) < 10) ? faulty_health() : HEALTH_ALL_OK,
                             next_token($urandom_range(0, 9) == 0), 1'($urandom));
            end
            else if (kind < 88)
            begin
                n = $urandom_range(2, 5);
                m = 4'($urandom_range(0, 8));
                repeat (n)
                    add_tick(m, AST_EMERGENCY, 2'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) == 0) ? faulty_health() : HEALTH_ALL_OK,
                             next_token($urandom_range(0, 3) == 0), 1'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    add_tick(4'($urandom), 3'($urandom), 2'($urandom), 7'($urandom),
                             next_token($urandom_range(0, 3) == 0), 1'($urandom));
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (tick_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d ticks and %0d result words, one long result stall included.",
                 ticks_in, results_seen);
        $display("Armed %0d ticks, acknowledged %0d resets, %0d bench steering ticks, %0d host latches.",
                 armed_ticks, resets_acked, bench_steers, host_latches);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout with %0d result words still outstanding", verdict_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
